/* sv/fbc_pkg.sv */
// Shared types, codes and constants for the framebuffer to BGRA converter.
package fbc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int CFG_W           = 13;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [2:0] DEPTH_1BIT  = 3'd0;
   localparam logic [2:0] DEPTH_2BIT  = 3'd1;
   localparam logic [2:0] DEPTH_4BIT  = 3'd2;
   localparam logic [2:0] DEPTH_8BIT  = 3'd3;
   localparam logic [2:0] DEPTH_16BIT = 3'd4;
   localparam logic [2:0] DEPTH_32BIT = 3'd5;

   localparam logic [1:0] CSR_DEPTH_CODE  = 2'd0;
   localparam logic [1:0] CSR_LINE_PIXELS = 2'd1;
   localparam logic [1:0] CSR_FRAME_ROWS  = 2'd2;
   localparam logic [1:0] CSR_ROW_WORDS   = 2'd3;

   localparam logic [2:0]       RST_DEPTH_CODE  = DEPTH_32BIT;
   localparam logic [CFG_W-1:0] RST_LINE_PIXELS = 13'd800;
   localparam logic [CFG_W-1:0] RST_FRAME_ROWS  = 13'd600;
   localparam logic [CFG_W-1:0] RST_ROW_WORDS   = 13'd800;

   typedef enum logic [1:0] {
      KIND_PAL  = 2'd0,
      KIND_WORD = 2'd1,
      KIND_SKIP = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
   } entry_type;

   typedef struct packed {
      logic [2:0]       depth_code;
      logic [CFG_W-1:0] line_pixels;
      logic [CFG_W-1:0] frame_rows;
      logic [CFG_W-1:0] row_words;
   } cfg_type;

endpackage

/* sv/framebuffer_to_bgra_converter_top.sv */
// Top level of the framebuffer to BGRA converter: config registers and part wiring.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    func, source word, palette write
//   rsp      out        rsp_valid/rsp_ready    one BGRA pixel with position flags
//   csr      in         csr_we                 csr_index, csr_wdata (13 bits)
//
// A packed word gives one visible pixel per cycle (up to 32) while rsp is
// not stalled, set by the single pixel slot of the back end. A palette
// write or a word with no visible pixel leaves the queue even when rsp
// stalls. Pixels pass the two-entry queue, then the output register. The
// palette reads as a gray ramp after reset until entries are written; no
// clearing pass. A stalled rsp holds the back end while req fills the queue.
module framebuffer_to_bgra_converter_top
   import fbc_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [31:0]      req_source_word,
   input  logic [7:0]       req_palette_index,
   input  logic [7:0]       req_palette_red,
   input  logic [7:0]       req_palette_green,
   input  logic [7:0]       req_palette_blue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_alpha,
   output logic [11:0]      rsp_pixel_column,
   output logic             rsp_row_end,
   output logic             rsp_frame_end,
   output logic             rsp_run_last,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full, push, pop, head_valid;
   entry_type push_entry, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEPTH_CODE:  cfg_in.depth_code  = csr_wdata[2:0];
            CSR_LINE_PIXELS: cfg_in.line_pixels = csr_wdata;
            CSR_FRAME_ROWS:  cfg_in.frame_rows  = csr_wdata;
            CSR_ROW_WORDS:   cfg_in.row_words   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_code  <= RST_DEPTH_CODE;
         cfg_ff.line_pixels <= RST_LINE_PIXELS;
         cfg_ff.frame_rows  <= RST_FRAME_ROWS;
         cfg_ff.row_words   <= RST_ROW_WORDS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbc_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_source_word   (req_source_word),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .depth_code        (cfg_ff.depth_code),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   fbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   fbc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_alpha        (rsp_alpha),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

/* sv/fbc_front.sv */
// Request intake: classifies each request and packs it into a queue entry.
module fbc_front
   import fbc_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_source_word,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_palette_red,
   input  logic [7:0]  req_palette_green,
   input  logic [7:0]  req_palette_blue,
   input  logic [2:0]  depth_code,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   always_comb begin
      push_entry = '0;
      if (req_func) begin
         push_entry.kind = KIND_PAL;
         push_entry.data = {req_palette_index, req_palette_red,
                            req_palette_green, req_palette_blue};
      end else begin
         push_entry.data = req_source_word;
         if (depth_code inside {[DEPTH_1BIT:DEPTH_32BIT]}) begin
            push_entry.kind = KIND_WORD;
         end else begin
            push_entry.kind = KIND_SKIP;
         end
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* sv/fbc_queue.sv */
// Short FIFO between request intake and pixel back end.
module fbc_queue
   import fbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

endmodule

/* sv/fbc_back.sv */
// Back end: pixel unpacking, palette store, position counters, output stage.
module fbc_back
   import fbc_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        head_valid,
   input  entry_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_alpha,
   output logic [11:0] rsp_pixel_column,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   output logic        rsp_run_last
);

   localparam int COL_W = $clog2(MAX_WIDTH + 1);

   // position state
   logic [COL_W-1:0] col_ff, col_in;
   logic [CFG_W-1:0] word_ff, word_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic [4:0]       sub_ff, sub_in;

   // palette
   logic [23:0]                pal_mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_valid_ff;
   logic [23:0]                pal_rdata_ff;

   // output stage
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_lut_ff;
   logic             s2_hit_ff;
   logic [7:0]       s2_idx_ff;
   logic [7:0]       s2_blue_ff, s2_green_ff, s2_red_ff, s2_alpha_ff;
   logic [11:0]      s2_col_ff;
   logic             s2_rend_ff, s2_fend_ff, s2_last_ff;

   logic [COL_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff, rwords_eff;
   logic             is_pal, is_word, vis, advance, emit, px_last, word_done;
   logic [4:0]       last_sub, off;
   logic [31:0]      aligned;
   logic [7:0]       pix_idx;
   logic             use_lut;
   logic [7:0]       px_blue, px_green, px_red, px_alpha;
   logic             rend, fend;
   logic [CFG_W:0]   word_inc, row_inc;
   logic [PAL_IDX_W-1:0] wr_idx;

   always_comb begin
      if ({1'b0, cfg.line_pixels} > (CFG_W + 1)'(MAX_WIDTH)) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = COL_W'(cfg.line_pixels);
      end
      height_eff = (cfg.frame_rows == '0) ? CFG_W'(1) : cfg.frame_rows;
      rwords_eff = (cfg.row_words == '0) ? CFG_W'(1) : cfg.row_words;
   end

   always_comb begin
      case (cfg.depth_code)
         DEPTH_1BIT:  last_sub = 5'd31;
         DEPTH_2BIT:  last_sub = 5'd15;
         DEPTH_4BIT:  last_sub = 5'd7;
         DEPTH_8BIT:  last_sub = 5'd3;
         DEPTH_16BIT: last_sub = 5'd1;
         default:     last_sub = 5'd0;
      endcase
   end

   // pixel extraction, MSB first
   always_comb begin
      off      = 5'(sub_ff << cfg.depth_code);
      aligned  = head.data << off;
      pix_idx  = '0;
      use_lut  = 1'b0;
      px_alpha = 8'hFF;
      px_red   = '0;
      px_green = '0;
      px_blue  = '0;
      case (cfg.depth_code)
         DEPTH_1BIT: begin
            pix_idx = 8'(aligned[31]);
            use_lut = 1'b1;
         end
         DEPTH_2BIT: begin
            pix_idx = 8'(aligned[31:30]);
            use_lut = 1'b1;
         end
         DEPTH_4BIT: begin
            pix_idx = 8'(aligned[31:28]);
            use_lut = 1'b1;
         end
         DEPTH_8BIT: begin
            pix_idx = aligned[31:24];
            use_lut = 1'b1;
         end
         DEPTH_16BIT: begin
            px_red   = {aligned[30:26], 3'b000};
            px_green = {aligned[25:21], 3'b000};
            px_blue  = {aligned[20:16], 3'b000};
         end
         default: begin
            px_alpha = head.data[31:24];
            px_red   = head.data[23:16];
            px_green = head.data[15:8];
            px_blue  = head.data[7:0];
         end
      endcase
   end

   always_comb begin
      is_pal    = (head.kind == KIND_PAL);
      is_word   = (head.kind == KIND_WORD);
      vis       = is_word && (col_ff < width_eff);
      advance   = !s2_valid_ff || rsp_ready;
      emit      = head_valid && vis && advance;
      rend      = ((col_ff + 1'b1) == width_eff);
      row_inc   = {1'b0, row_ff} + 1'b1;
      word_inc  = {1'b0, word_ff} + 1'b1;
      fend      = rend && (row_inc == {1'b0, height_eff});
      px_last   = (sub_ff == last_sub) || rend;
      word_done = head_valid && !is_pal && (!vis || (advance && px_last));
      pop       = head_valid && (is_pal || word_done);
      wr_idx    = head.data[31:24];
   end

   always_comb begin
      col_in  = col_ff;
      word_in = word_ff;
      row_in  = row_ff;
      sub_in  = sub_ff;
      if (emit) begin
         col_in = col_ff + 1'b1;
         sub_in = sub_ff + 1'b1;
      end
      if (word_done) begin
         sub_in = '0;
         if (word_inc >= {1'b0, rwords_eff}) begin
            word_in = '0;
            col_in  = '0;
            if (row_inc >= {1'b0, height_eff}) begin
               row_in = '0;
            end else begin
               row_in = row_inc[CFG_W-1:0];
            end
         end else begin
            word_in = word_inc[CFG_W-1:0];
         end
      end
   end

   assign s2_valid_in = advance ? emit : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         word_ff      <= '0;
         row_ff       <= '0;
         sub_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         pal_valid_ff <= '0;
      end else begin
         col_ff      <= col_in;
         word_ff     <= word_in;
         row_ff      <= row_in;
         sub_ff      <= sub_in;
         s2_valid_ff <= s2_valid_in;
         if (head_valid && is_pal) begin
            pal_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_valid && is_pal) begin
         pal_mem_ff[wr_idx] <= head.data[23:0];
      end
      if (emit) begin
         pal_rdata_ff <= pal_mem_ff[pix_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s2_lut_ff   <= use_lut;
         s2_hit_ff   <= pal_valid_ff[pix_idx];
         s2_idx_ff   <= pix_idx;
         s2_blue_ff  <= px_blue;
         s2_green_ff <= px_green;
         s2_red_ff   <= px_red;
         s2_alpha_ff <= px_alpha;
         s2_col_ff   <= 12'(col_ff);
         s2_rend_ff  <= rend;
         s2_fend_ff  <= fend;
         s2_last_ff  <= px_last;
      end
   end

   // unwritten palette entries read as the gray ramp
   always_comb begin
      if (s2_lut_ff) begin
         if (s2_hit_ff) begin
            rsp_red   = pal_rdata_ff[23:16];
            rsp_green = pal_rdata_ff[15:8];
            rsp_blue  = pal_rdata_ff[7:0];
         end else begin
            rsp_red   = s2_idx_ff;
            rsp_green = s2_idx_ff;
            rsp_blue  = s2_idx_ff;
         end
      end else begin
         rsp_red   = s2_red_ff;
         rsp_green = s2_green_ff;
         rsp_blue  = s2_blue_ff;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_alpha        = s2_alpha_ff;
   assign rsp_pixel_column = s2_col_ff;
   assign rsp_row_end      = s2_rend_ff;
   assign rsp_frame_end    = s2_fend_ff;
   assign rsp_run_last     = s2_last_ff;

endmodule

/* dv/fbc_pixel_checker.sv */
// Pixel checker: mirrors the converter state, predicts every pixel and compares results.
module fbc_pixel_checker
   import fbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_func,
   input  logic [31:0]      req_source_word,
   input  logic [7:0]       req_palette_index,
   input  logic [7:0]       req_palette_red,
   input  logic [7:0]       req_palette_green,
   input  logic [7:0]       req_palette_blue,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [7:0]       rsp_blue,
   input  logic [7:0]       rsp_green,
   input  logic [7:0]       rsp_red,
   input  logic [7:0]       rsp_alpha,
   input  logic [11:0]      rsp_pixel_column,
   input  logic             rsp_row_end,
   input  logic             rsp_frame_end,
   input  logic             rsp_run_last,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pixels_pending,
   output int               pixels_checked
);

   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic [11:0] column;
      logic        row_end;
      logic        frame_end;
      logic        run_last;
   } pixel_type;

   pixel_type        expected_pixels[$];
   logic [23:0]      palette[PALETTE_ENTRIES];
   logic [2:0]       depth_reg;
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [CFG_W-1:0] row_words_reg;
   int               col_pos;
   int               word_pos;
   int               row_pos;
   int               mismatches = 0;
   int               checked_total = 0;

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int got, int want, int column);
      if (got != want)
         report_mismatch($sformatf("%s at column %0d: got %0h, expected %0h",
                                   name, column, got, want));
   endtask

   // Unpack one source word MSB first and queue its visible pixels.
   function automatic void unpack_word(logic [31:0] word);
      int          bits;
      int          lanes;
      int          width;
      int          height;
      int          rwords;
      int          shift;
      int          k;
      logic [15:0] half;
      logic [7:0]  index;
      logic [23:0] rgb;
      pixel_type   px;
      case (depth_reg)
         DEPTH_1BIT:  bits = 1;
         DEPTH_2BIT:  bits = 2;
         DEPTH_4BIT:  bits = 4;
         DEPTH_8BIT:  bits = 8;
         DEPTH_16BIT: bits = 16;
         DEPTH_32BIT: bits = 32;
         default:     bits = 0;
      endcase
      lanes  = (bits == 0) ? 0 : 32 / bits;
      width  = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
      height = (height_reg == 0) ? 1 : int'(height_reg);
      rwords = (row_words_reg == 0) ? 1 : int'(row_words_reg);
      for (k = 0; k < lanes && col_pos < width; k++) begin
         shift = 32 - bits * (k + 1);
         if (bits == 32) begin
            px.alpha = word[31:24];
            px.red   = word[23:16];
            px.green = word[15:8];
            px.blue  = word[7:0];
         end else if (bits == 16) begin
            half     = 16'(word >> shift);
            px.red   = {half[14:10], 3'b000};
            px.green = {half[9:5], 3'b000};
            px.blue  = {half[4:0], 3'b000};
            px.alpha = 8'hFF;
         end else begin
            index    = 8'((word >> shift) & ((32'd1 << bits) - 32'd1));
            rgb      = palette[index];
            px.red   = rgb[23:16];
            px.green = rgb[15:8];
            px.blue  = rgb[7:0];
            px.alpha = 8'hFF;
         end
         px.column    = 12'(col_pos);
         px.row_end   = (col_pos + 1 == width);
         px.frame_end = px.row_end && (row_pos + 1 == height);
         px.run_last  = (k == lanes - 1) || (col_pos + 1 >= width);
         expected_pixels.push_back(px);
         col_pos++;
      end
      word_pos++;
      if (word_pos >= rwords) begin
         word_pos = 0;
         col_pos  = 0;
         row_pos++;
         if (row_pos >= height)
            row_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      int        i;
      if (reset) begin
         for (i = 0; i < PALETTE_ENTRIES; i++)
            palette[i] = {3{8'(i)}};
         depth_reg     = RST_DEPTH_CODE;
         width_reg     = RST_LINE_PIXELS;
         height_reg    = RST_FRAME_ROWS;
         row_words_reg = RST_ROW_WORDS;
         col_pos       = 0;
         word_pos      = 0;
         row_pos       = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel at column %0d with none expected",
                                         rsp_pixel_column));
            end else begin
               want = expected_pixels.pop_front();
               check_field("blue", rsp_blue, want.blue, want.column);
               check_field("green", rsp_green, want.green, want.column);
               check_field("red", rsp_red, want.red, want.column);
               check_field("alpha", rsp_alpha, want.alpha, want.column);
               check_field("column", rsp_pixel_column, want.column, want.column);
               check_field("row_end", rsp_row_end, want.row_end, want.column);
               check_field("frame_end", rsp_frame_end, want.frame_end, want.column);
               check_field("run_last", rsp_run_last, want.run_last, want.column);
               checked_total++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_func)
               palette[req_palette_index] = {req_palette_red, req_palette_green,
                                             req_palette_blue};
            else
               unpack_word(req_source_word);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEPTH_CODE:  depth_reg = csr_wdata[2:0];
               CSR_LINE_PIXELS: width_reg = csr_wdata;
               CSR_FRAME_ROWS:  height_reg = csr_wdata;
               CSR_ROW_WORDS:   row_words_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count     <= mismatches;
      pixels_pending <= expected_pixels.size();
      pixels_checked <= checked_total;
   end

endmodule

/* dv/framebuffer_to_bgra_converter_top_tb.sv */
// Testbench top: drives requests and CSR writes into the converter and reports the verdict.
module framebuffer_to_bgra_converter_top_tb
   import fbc_pkg::*;
();

   typedef enum int {
      PACE_SLOW_SINK,
      PACE_SLOW_SOURCE,
      PACE_FULL
   } pace_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_func = 1'b0;
   logic [31:0]      req_source_word = '0;
   logic [7:0]       req_palette_index = '0;
   logic [7:0]       req_palette_red = '0;
   logic [7:0]       req_palette_green = '0;
   logic [7:0]       req_palette_blue = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_blue;
   logic [7:0]       rsp_green;
   logic [7:0]       rsp_red;
   logic [7:0]       rsp_alpha;
   logic [11:0]      rsp_pixel_column;
   logic             rsp_row_end;
   logic             rsp_frame_end;
   logic             rsp_run_last;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = CSR_DEPTH_CODE;
   logic [CFG_W-1:0] csr_wdata = '0;

   int       fail_count;
   int       pixels_pending;
   int       pixels_checked;
   pace_type pace = PACE_SLOW_SINK;
   int       words_sent = 0;
   int       palette_sent = 0;
   int       settings_used = 0;

   always #4 clock = ~clock;

   framebuffer_to_bgra_converter_top uut (.*);

   fbc_pixel_checker pixel_check (.*);

   always @(posedge clock) begin
      case (pace)
         PACE_SLOW_SINK:   rsp_ready <= ($urandom_range(99) >= 62);
         PACE_SLOW_SOURCE: rsp_ready <= ($urandom_range(99) >= 26);
         default:          rsp_ready <= 1'b1;
      endcase
   end

   // Returns in the cycle the request is taken; req_valid is left high.
   task automatic send_request(logic func, logic [31:0] word, logic [7:0] index,
                               logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int gap;
      int pct;
      gap = 0;
      pct = (pace == PACE_SLOW_SINK) ? 26 : (pace == PACE_SLOW_SOURCE) ? 62 : 0;
      while ($urandom_range(99) < pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_source_word   <= word;
      req_palette_index <= index;
      req_palette_red   <= red;
      req_palette_green <= green;
      req_palette_blue  <= blue;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (func)
         palette_sent++;
      else
         words_sent++;
   endtask

   task automatic send_word(logic [31:0] word);
      send_request(1'b0, word, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(logic [2:0] depth, logic [CFG_W-1:0] width,
                             logic [CFG_W-1:0] height, logic [CFG_W-1:0] rwords);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEPTH_CODE;
      csr_wdata <= {10'($urandom), depth};
      @(posedge clock);
      csr_index <= CSR_LINE_PIXELS;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= CSR_FRAME_ROWS;
      csr_wdata <= height;
      @(posedge clock);
      csr_index <= CSR_ROW_WORDS;
      csr_wdata <= rwords;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random_setting(int count);
      logic [2:0] depth;
      int         lanes;
      int         width;
      int         words_row;
      int         rwords;
      int         height;
      if ($urandom_range(11) == 0)
         depth = 3'(DEPTH_32BIT + 1 + $urandom_range(1));
      else
         depth = 3'($urandom_range(DEPTH_1BIT, DEPTH_32BIT));
      lanes     = (depth > DEPTH_32BIT) ? 1 : (32 >> depth);
      width     = ($urandom_range(14) == 0) ? 0 : $urandom_range(1, lanes * 6);
      words_row = (width + lanes - 1) / lanes;
      if ($urandom_range(14) == 0)
         rwords = 0;
      else if ($urandom_range(3) == 0)
         rwords = (words_row > 1) ? words_row - 1 : 1;
      else
         rwords = words_row + $urandom_range(2);
      height = ($urandom_range(14) == 0) ? 0 : $urandom_range(1, 3);
      wait_idle();
      set_config(depth, CFG_W'(width), CFG_W'(height), CFG_W'(rwords));
      repeat (count) begin
         if ($urandom_range(9) == 0)
            send_request(1'b1, $urandom,
                         ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
         else
            send_word($urandom);
      end
   endtask

   initial begin
      logic [31:0] corner_words[8];
      int          p;
      int          n;
      int          pass_items;
      int          drain;
      corner_words = '{32'h00000000, 32'hFFFFFFFF, 32'h80FF0001,
                       32'h7F00FF80, 32'h12345678, 32'hA5A55A5A,
                       32'hC3963C69, 32'h00FF00FF};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // 32-bit words: padding word, row and frame wrap
      set_config(DEPTH_32BIT, 3, 2, 4);
      foreach (corner_words[i])
         send_word(corner_words[i]);
      send_request(1'b1, 32'h0, 8'hFF, 8'hFF, 8'h00, 8'h80);
      send_request(1'b1, 32'hFFFFFFFF, 8'h00, 8'h00, 8'hFF, 8'h7F);
      send_request(1'b1, 32'h0, 8'h01, 8'h12, 8'h34, 8'h56);
      // indexed and 16-bit depths
      wait_idle();
      set_config(DEPTH_1BIT, 40, 1, 2);
      send_word(32'hFFFFFFFF);
      send_word(32'h80000001);
      wait_idle();
      set_config(DEPTH_2BIT, 16, 1, 1);
      send_word(32'h1B1BE4E4);
      wait_idle();
      set_config(DEPTH_4BIT, 8, 1, 1);
      send_word(32'h0123FEDC);
      wait_idle();
      set_config(DEPTH_8BIT, 4, 1, 1);
      send_word(32'hFF00017F);
      wait_idle();
      set_config(DEPTH_16BIT, 2, 1, 1);
      send_word(32'h7FFF8000);
      // unused depth codes
      wait_idle();
      set_config(DEPTH_32BIT + 3'd1, 8, 1, 1);
      send_word(32'hFFFFFFFF);
      wait_idle();
      set_config(DEPTH_32BIT + 3'd2, 8, 1, 1);
      send_word(32'hFFFFFFFF);
      // zero sizes
      wait_idle();
      set_config(DEPTH_32BIT, 0, 0, 0);
      send_word(32'h11223344);
      send_word(32'h55667788);
      wait_idle();
      set_config(DEPTH_32BIT, 1, 0, 0);
      send_word(32'h99AABBCC);
      send_word(32'hDDEEFF00);

      for (p = 0; p < 3; p++) begin
         pace       = pace_type'(p);
         pass_items = 0;
         if (p == 0) begin
            // width beyond the maximum, largest height and row length
            wait_idle();
            set_config(DEPTH_1BIT, 13'h1FFF, 13'h1FFF, 129);
            repeat (131) send_word($urandom);
            wait_idle();
            set_config(DEPTH_32BIT, 13'h1FFF, 13'h1FFF, 13'h1FFF);
            repeat (12) send_word($urandom);
         end
         while (pass_items < 70) begin
            n = $urandom_range(12, 40);
            run_random_setting(n);
            pass_items += n;
         end
      end

      req_valid <= 1'b0;
      drain = 0;
      @(posedge clock);
      while (pixels_pending != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (pixels_pending != 0)
         $display("%0d expected pixels never arrived", pixels_pending);
      $display("Sent %0d source words and %0d palette writes over %0d register settings,",
               words_sent, palette_sent, settings_used);
      $display("all depth codes, zero and oversized frames; %0d pixels compared.",
               pixels_checked);
      if (fail_count == 0 && pixels_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d pixels outstanding", pixels_pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
